FILE: sv/fir_convolution_with_feedback_mix_top_defines.svh
// ----------------------------------------------------------------------------
// fir_convolution_with_feedback_mix_top_defines.svh
// Assertion macros for the convolution block; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef FIR_CONVOLUTION_WITH_FEEDBACK_MIX_TOP_DEFINES_SVH
`define FIR_CONVOLUTION_WITH_FEEDBACK_MIX_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define FCM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

`define FCM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FCM_ASSERT(lbl, prop, msg)

`define FCM_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: sv/fcm_pkg.sv
// ----------------------------------------------------------------------------
// fcm_pkg
// Shared widths, codes, reset values and state type of the convolution block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fcm_pkg;

    localparam int MAX_TAPS_DEF = 1024;

    localparam int SAMPLE_W    = 16;
    localparam int Q15_W       = 16;
    localparam int TAP_IDX_W   = 10;
    localparam int WET_GAIN_W  = 24;
    localparam int TAP_CNT_W   = 11;
    localparam int Q15_ONE     = 32768;

    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int REG_SEL_BIT = 2;

    localparam logic [WET_GAIN_W-1:0] WET_GAIN_RST = WET_GAIN_W'(65536);
    localparam logic [TAP_CNT_W-1:0]  TAP_CNT_RST  = TAP_CNT_W'(1024);

    localparam int GM_W      = WET_GAIN_W + Q15_W;
    localparam int SAT_BIT   = 62;
    localparam int DRY_SHIFT = 31;
    localparam int OUT_SHIFT = 46;
    localparam int V_W       = 64 - OUT_SHIFT;

    localparam logic signed [SAMPLE_W-1:0] S16_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] S16_MIN = 16'sh8000;

    typedef enum logic [0:0] {
        MODE_LOAD   = 1'b0,
        MODE_SAMPLE = 1'b1
    } mode_t;

    typedef enum logic [0:0] {
        REG_WET_GAIN  = 1'b0,
        REG_TAP_COUNT = 1'b1
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FB_MUL,
        ST_FB_WR,
        ST_MAC,
        ST_DRAIN,
        ST_GM,
        ST_SER,
        ST_WET,
        ST_SCALE,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

FILE: sv/fir_convolution_with_feedback_mix_top.sv
// ----------------------------------------------------------------------------
// fir_convolution_with_feedback_mix_top
// Direct-form FIR convolution with a feedback-mixed delay line and wet/dry mix.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (s_valid/s_ready) carry either a coefficient load (s_mode 0)
//   or an audio sample (s_mode 1). Result beats (m_valid/m_ready) carry one
//   m_sample_out per sample; loads give no result.
//   Registers on the APB port: wet_gain at 0x0, tap_count at 0x4.
//   A load is written as it is accepted. A sample with n taps in use runs
//   one delay read, one feedback write-back, the single multiply-accumulate
//   loop over n entries of the delay and coefficient memories (one tap per
//   cycle), a drain, a bit-serial wet-gain multiply, scaling and clipping.
//   The next beat can be taken in the same cycle that m_valid rises.
//   After reset the delay memory is cleared, one entry per cycle, through all
//   MAX_TAPS entries; s_ready stays low meanwhile, register writes are taken.
//   A result waits in the output register while the receiver stalls; the
//   next item is still accepted, and the following result holds in its
//   last step until the output register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "fir_convolution_with_feedback_mix_top_defines.svh"

module fir_convolution_with_feedback_mix_top #(
    parameter int MAX_TAPS = fcm_pkg::MAX_TAPS_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,

    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic                                 s_mode,
    input  wire logic        [fcm_pkg::TAP_IDX_W-1:0] s_tap_index,
    input  wire logic signed [fcm_pkg::SAMPLE_W-1:0]  s_tap_value,
    input  wire logic signed [fcm_pkg::SAMPLE_W-1:0]  s_sample_in,
    input  wire logic        [fcm_pkg::Q15_W-1:0]     s_wet_mix,
    input  wire logic        [fcm_pkg::Q15_W-1:0]     s_feedback,

    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic signed      [fcm_pkg::SAMPLE_W-1:0]  m_sample_out,

    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic        [fcm_pkg::PADDR_W-1:0]   paddr,
    input  wire logic        [fcm_pkg::PDATA_W-1:0]   pwdata,
    output logic             [fcm_pkg::PDATA_W-1:0]   prdata,
    output logic                                      pready
);

    import fcm_pkg::*;

    localparam int ADDR_W    = $clog2(MAX_TAPS);
    localparam int N_W       = $clog2(MAX_TAPS + 1);
    localparam int ACC_W     = 2 * SAMPLE_W + ADDR_W + 1;
    localparam int PROD_W    = ACC_W + GM_W;
    localparam int BIT_CNT_W = $clog2(GM_W);
    localparam logic signed [63:0] RND_BIAS = (64'sd1 <<< OUT_SHIFT) - 64'sd1;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [WET_GAIN_W-1:0] wet_gain_reg;
    logic [TAP_CNT_W-1:0]  tap_count_reg;
    logic                  cfg_we;
    reg_idx_t              reg_sel;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign reg_sel = reg_idx_t'(paddr[REG_SEL_BIT]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wet_gain_reg  <= WET_GAIN_RST;
            tap_count_reg <= TAP_CNT_RST;
        end else if (cfg_we) begin
            case (reg_sel)
                REG_WET_GAIN:  wet_gain_reg  <= pwdata[WET_GAIN_W-1:0];
                REG_TAP_COUNT: tap_count_reg <= pwdata[TAP_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_WET_GAIN:  prdata = PDATA_W'(wet_gain_reg);
            REG_TAP_COUNT: prdata = PDATA_W'(tap_count_reg);
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // control state
    // ------------------------------------------------------------------
    state_t                 state_reg, state_next;
    logic                   clr_done_reg;
    logic [ADDR_W-1:0]      clr_addr_reg;
    logic [ADDR_W-1:0]      wp_reg;
    logic                   v1_reg, v2_reg;
    logic                   m_valid_reg;
    logic                   accept, sample_acc, load_acc, out_load;

    // payload registers
    logic [N_W-1:0]                 n_reg;
    logic [ADDR_W-1:0]              p_reg;
    logic signed [SAMPLE_W-1:0]     x_reg;
    logic [Q15_W-1:0]               m_reg;
    logic [Q15_W-1:0]               f_reg;
    logic signed [2*SAMPLE_W+1:0]   num_reg;
    logic signed [2*SAMPLE_W:0]     d_reg;
    logic [ADDR_W-1:0]              idx_reg;
    logic [ADDR_W-1:0]              k_reg;
    logic signed [2*SAMPLE_W-1:0]   mac_prod_reg;
    logic signed [ACC_W-1:0]        acc_reg;
    logic                           neg_reg;
    logic [GM_W-1:0]                gm_reg;
    logic [PROD_W-1:0]              mag_reg;
    logic [PROD_W-1:0]              wprod_reg;
    logic [BIT_CNT_W-1:0]           bit_cnt_reg;
    logic                           sat_reg;
    logic signed [63:0]             t_reg;
    logic signed [V_W-1:0]          v_reg;
    logic signed [SAMPLE_W-1:0]     out_reg;

    // derived values
    logic [N_W-1:0]                 n_comb;
    logic [ADDR_W-1:0]              p_comb;
    logic [Q15_W-1:0]               m_sat, f_sat;
    logic                           mac_last;
    logic [31:0]                    tap_idx_wide;
    logic                           tap_ok;

    // memories
    logic                           dly_we;
    logic [ADDR_W-1:0]              dly_waddr, dly_raddr;
    logic [SAMPLE_W-1:0]            dly_wdata, dly_rdata;
    logic                           coef_we;
    logic [SAMPLE_W-1:0]            coef_rdata;

    // datapath combinational
    logic signed [SAMPLE_W:0]       fb_diff;
    logic signed [2*SAMPLE_W+1:0]   num_next;
    logic signed [2*SAMPLE_W+3:0]   fb_full;
    logic signed [2*SAMPLE_W+3:0]   fb_round;
    logic [SAMPLE_W-1:0]            fb_val;
    logic [Q15_W-1:0]               dry_share;
    logic signed [2*SAMPLE_W:0]     d_next;
    logic [ACC_W-1:0]               acc_abs;
    logic signed [63:0]             q_sgn, t_next, t_biased;
    logic signed [SAMPLE_W-1:0]     out_next;

    assign accept     = s_valid && s_ready;
    assign sample_acc = accept && (mode_t'(s_mode) == MODE_SAMPLE);
    assign load_acc   = accept && (mode_t'(s_mode) == MODE_LOAD);

    always_comb begin
        if (tap_count_reg == '0) begin
            n_comb = N_W'(1);
        end else if (32'(tap_count_reg) > 32'(MAX_TAPS)) begin
            n_comb = N_W'(MAX_TAPS);
        end else begin
            n_comb = N_W'(tap_count_reg);
        end
    end

    assign p_comb = (N_W'(wp_reg) >= n_comb) ? '0 : wp_reg;
    assign m_sat  = (s_wet_mix > Q15_W'(Q15_ONE)) ? Q15_W'(Q15_ONE) : s_wet_mix;
    assign f_sat  = (s_feedback > Q15_W'(Q15_ONE)) ? Q15_W'(Q15_ONE) : s_feedback;

    assign mac_last     = (N_W'(k_reg) == (n_reg - N_W'(1)));
    assign tap_idx_wide = 32'(s_tap_index);
    assign tap_ok       = tap_idx_wide < 32'(MAX_TAPS);

    // ------------------------------------------------------------------
    // state machine
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = clr_done_reg;
                if (sample_acc) begin
                    state_next = ST_FB_MUL;
                end
            end
            ST_FB_MUL: state_next = ST_FB_WR;
            ST_FB_WR:  state_next = ST_MAC;
            ST_MAC: begin
                if (mac_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!v1_reg && !v2_reg) begin
                    state_next = ST_GM;
                end
            end
            ST_GM: state_next = ST_SER;
            ST_SER: begin
                if (bit_cnt_reg == BIT_CNT_W'(GM_W - 1)) begin
                    state_next = ST_WET;
                end
            end
            ST_WET:   state_next = ST_SCALE;
            ST_SCALE: state_next = ST_OUT;
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_done_reg <= 1'b0;
            clr_addr_reg <= '0;
            wp_reg       <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (!clr_done_reg) begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(MAX_TAPS - 1)) begin
                    clr_done_reg <= 1'b1;
                end
            end
            if (state_reg == ST_FB_WR) begin
                wp_reg <= ((N_W'(p_reg) + N_W'(1)) >= n_reg) ? '0 : p_reg + ADDR_W'(1);
            end
            v1_reg <= (state_reg == ST_MAC);
            v2_reg <= v1_reg;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // memories
    // ------------------------------------------------------------------
    assign dly_we    = !clr_done_reg || (state_reg == ST_FB_WR);
    assign dly_waddr = clr_done_reg ? p_reg : clr_addr_reg;
    assign dly_wdata = clr_done_reg ? fb_val : '0;
    assign dly_raddr = (state_reg == ST_MAC) ? idx_reg : p_comb;
    assign coef_we   = load_acc && tap_ok;

    fcm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_TAPS)
    ) u_dly_ram (
        .aclk  (aclk),
        .we    (dly_we),
        .waddr (dly_waddr),
        .wdata (dly_wdata),
        .raddr (dly_raddr),
        .rdata (dly_rdata)
    );

    fcm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_TAPS)
    ) u_coef_ram (
        .aclk  (aclk),
        .we    (coef_we),
        .waddr (tap_idx_wide[ADDR_W-1:0]),
        .wdata (s_tap_value),
        .raddr (k_reg),
        .rdata (coef_rdata)
    );

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    assign fb_diff   = $signed({dly_rdata[SAMPLE_W-1], dly_rdata}) -
                       $signed({x_reg[SAMPLE_W-1], x_reg});
    assign num_next  = (2*SAMPLE_W+2)'($signed({1'b0, f_reg})) *
                       (2*SAMPLE_W+2)'(fb_diff);
    assign fb_full   = (2*SAMPLE_W+4)'(num_reg) + ((2*SAMPLE_W+4)'(x_reg) <<< 15);
    assign fb_round  = fb_full + (fb_full[2*SAMPLE_W+3] ? (2*SAMPLE_W+4)'(32767)
                                                        : (2*SAMPLE_W+4)'(0));
    assign fb_val    = SAMPLE_W'(fb_round >>> 15);
    assign dry_share = Q15_W'(Q15_ONE) - m_reg;
    assign d_next    = (2*SAMPLE_W+1)'(x_reg) *
                       (2*SAMPLE_W+1)'($signed({1'b0, dry_share}));
    assign acc_abs   = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign q_sgn     = neg_reg ? -$signed(64'(wprod_reg[SAT_BIT-1:0]))
                               : $signed(64'(wprod_reg[SAT_BIT-1:0]));
    assign t_next    = q_sgn + (64'(d_reg) <<< DRY_SHIFT);
    assign t_biased  = t_reg + (t_reg[63] ? RND_BIAS : 64'sd0);

    always_comb begin
        if (sat_reg) begin
            out_next = neg_reg ? S16_MIN : S16_MAX;
        end else if (v_reg > V_W'(S16_MAX)) begin
            out_next = S16_MAX;
        end else if (v_reg < V_W'(S16_MIN)) begin
            out_next = S16_MIN;
        end else begin
            out_next = SAMPLE_W'(v_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (sample_acc) begin
            n_reg <= n_comb;
            p_reg <= p_comb;
            x_reg <= s_sample_in;
            m_reg <= m_sat;
            f_reg <= f_sat;
        end
        if (state_reg == ST_FB_MUL) begin
            num_reg <= num_next;
        end
        if (state_reg == ST_FB_WR) begin
            d_reg   <= d_next;
            idx_reg <= p_reg;
            k_reg   <= '0;
            acc_reg <= '0;
        end
        if (state_reg == ST_MAC) begin
            idx_reg <= (idx_reg == '0) ? ADDR_W'(n_reg - N_W'(1)) : idx_reg - ADDR_W'(1);
            k_reg   <= k_reg + ADDR_W'(1);
        end
        mac_prod_reg <= $signed(dly_rdata) * $signed(coef_rdata);
        if (v2_reg) begin
            acc_reg <= acc_reg + ACC_W'(mac_prod_reg);
        end
        if (state_reg == ST_GM) begin
            gm_reg      <= GM_W'(wet_gain_reg) * GM_W'(m_reg);
            neg_reg     <= acc_reg[ACC_W-1];
            mag_reg     <= PROD_W'(acc_abs);
            wprod_reg   <= '0;
            bit_cnt_reg <= '0;
        end
        if (state_reg == ST_SER) begin
            if (gm_reg[0]) begin
                wprod_reg <= wprod_reg + mag_reg;
            end
            gm_reg      <= gm_reg >> 1;
            mag_reg     <= mag_reg << 1;
            bit_cnt_reg <= bit_cnt_reg + BIT_CNT_W'(1);
        end
        if (state_reg == ST_WET) begin
            sat_reg <= |wprod_reg[PROD_W-1:SAT_BIT];
            t_reg   <= t_next;
        end
        if (state_reg == ST_SCALE) begin
            v_reg <= V_W'(t_biased >>> OUT_SHIFT);
        end
        if (out_load) begin
            out_reg <= out_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = out_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `FCM_ASSERT(a_clr_quiet, !clr_done_reg |-> (!m_valid_reg && !s_ready), "beat during clear")
    `FCM_ASSERT(a_drain_empty, (state_reg == ST_GM) |-> (!v1_reg && !v2_reg), "MAC not drained")
    `FCM_ASSERT(a_tap_range, (state_reg == ST_MAC) |-> (N_W'(k_reg) < n_reg), "tap overrun")
    `FCM_ASSERT_NEXT(a_wp_range, state_reg == ST_FB_WR, N_W'(wp_reg) < n_reg, "pointer range")

endmodule

`default_nettype wire

FILE: sv/fcm_ram.sv
// ----------------------------------------------------------------------------
// fcm_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fcm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: dv/fcm_conv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcm_conv_checker
// Watches the sample, result and register ports of the convolution block.
// Keeps its own delay line, tap memory, pointer and register copies, works out
// each reverb output when a sample beat is taken and compares every result
// beat against the oldest outstanding prediction.
// ----------------------------------------------------------------------------

module fcm_conv_checker
    import fcm_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic                       s_mode,
    input  logic [TAP_IDX_W-1:0]       s_tap_index,
    input  logic signed [SAMPLE_W-1:0] s_tap_value,
    input  logic signed [SAMPLE_W-1:0] s_sample_in,
    input  logic [Q15_W-1:0]           s_wet_mix,
    input  logic [Q15_W-1:0]           s_feedback,

    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic signed [SAMPLE_W-1:0] m_sample_out,

    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [PADDR_W-1:0]         paddr,
    input  logic [PDATA_W-1:0]         pwdata,
    input  logic                       pready,

    output int                         mismatch_count,
    output int                         results_pending
);

    localparam int DEPTH = MAX_TAPS_DEF;

    logic signed [SAMPLE_W-1:0] history  [DEPTH];
    logic signed [SAMPLE_W-1:0] taps_mem [DEPTH];
    int unsigned                wr_ptr;
    logic [WET_GAIN_W-1:0]      gain_reg;
    logic [TAP_CNT_W-1:0]       taps_reg;
    logic signed [SAMPLE_W-1:0] due_samples [$];
    logic signed [SAMPLE_W-1:0] want;
    int                         errs;
    int                         reg_sel;

    function automatic logic signed [SAMPLE_W-1:0] reverb_sample(
        input logic signed [SAMPLE_W-1:0] dry_in,
        input logic [Q15_W-1:0]           mix_in,
        input logic [Q15_W-1:0]           fb_in
    );
        int unsigned          span, pos, idx, mix, keep;
        longint               mixed, acc;
        logic signed [127:0]  wet, mag, total, scaled, gain_w, mix_w, dry_w;
        span = taps_reg;
        if (span == 0) span = 1;
        if (span > DEPTH) span = DEPTH;
        pos  = (wr_ptr >= span) ? 0 : wr_ptr;
        mix  = (mix_in > Q15_ONE) ? Q15_ONE : mix_in;
        keep = (fb_in > Q15_ONE) ? Q15_ONE : fb_in;

        mixed = longint'(keep) * history[pos] + longint'(Q15_ONE - keep) * dry_in;
        history[pos] = SAMPLE_W'(mixed / Q15_ONE);

        acc = 0;
        idx = pos;
        for (int k = 0; k < span; k++) begin
            acc += longint'(history[idx]) * taps_mem[k];
            idx = (idx == 0) ? span - 1 : idx - 1;
        end
        wr_ptr = (pos + 1 >= span) ? 0 : pos + 1;

        gain_w = gain_reg;
        mix_w  = mix;
        dry_w  = dry_in;
        wet    = acc;
        wet    = wet * gain_w * mix_w;
        mag    = (wet < 0) ? -wet : wet;
        if (mag >= (128'sd1 <<< SAT_BIT))
            return (acc > 0) ? S16_MAX : S16_MIN;

        total  = wet + dry_w * (128'sd32768 - mix_w) * (128'sd1 <<< DRY_SHIFT);
        scaled = total / (128'sd1 <<< OUT_SHIFT);
        if (scaled > 32767) return S16_MAX;
        if (scaled < -32768) return S16_MIN;
        return scaled[SAMPLE_W-1:0];
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                history[i]  = '0;
                taps_mem[i] = '0;
            end
            wr_ptr   = 0;
            gain_reg = WET_GAIN_RST;
            taps_reg = TAP_CNT_RST;
            due_samples.delete();
            errs = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                reg_sel = paddr >> REG_SEL_BIT;
                if (reg_sel == REG_WET_GAIN)
                    gain_reg = pwdata[WET_GAIN_W-1:0];
                else if (reg_sel == REG_TAP_COUNT)
                    taps_reg = pwdata[TAP_CNT_W-1:0];
            end

            if (m_valid && m_ready) begin
                if (due_samples.size() == 0) begin
                    $error("sample_out: expected none, actual %0d", m_sample_out);
                    errs++;
                end else begin
                    want = due_samples.pop_front();
                    if (m_sample_out !== want) begin
                        $error("sample_out: expected %0d, actual %0d", want, m_sample_out);
                        errs++;
                    end
                end
            end

            if (s_valid && s_ready) begin
                if (s_mode == MODE_LOAD)
                    taps_mem[s_tap_index] = s_tap_value;
                else
                    due_samples.push_back(reverb_sample(s_sample_in, s_wet_mix, s_feedback));
            end
        end
        mismatch_count  <= errs;
        results_pending <= due_samples.size();
    end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the convolution block. Loads impulse-response taps,
// feeds directed corner samples, a back-pressure burst and randomized phases
// under changing gain and tap count, with random idle gaps on both channels.
// A separate checker predicts and compares every output sample.
// ----------------------------------------------------------------------------

module testbench;
    import fcm_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_ITEMS  = 580;
    localparam int QUIET_ITEMS   = 60;
    localparam int LONG_HOLD     = 600;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = MAX_TAPS_DEF + 64;
    localparam int WIDE_TAPS     = 256;

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic                       s_mode;
    logic [TAP_IDX_W-1:0]       s_tap_index;
    logic signed [SAMPLE_W-1:0] s_tap_value;
    logic signed [SAMPLE_W-1:0] s_sample_in;
    logic [Q15_W-1:0]           s_wet_mix;
    logic [Q15_W-1:0]           s_feedback;
    logic                       m_valid;
    logic                       m_ready;
    logic signed [SAMPLE_W-1:0] m_sample_out;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [PADDR_W-1:0]         paddr;
    logic [PDATA_W-1:0]         pwdata;
    logic [PDATA_W-1:0]         prdata;
    logic                       pready;

    int                         mismatch_count;
    int                         results_pending;
    int                         cycle_cnt = 0;
    bit                         idle_mode = 1'b1;
    bit                         quiet = 1'b0;
    bit                         wide_done = 1'b0;
    int                         hold_reqs = 0;
    int                         hold_served = 0;
    int                         prefix_loaded = 0;
    int                         cur_taps = MAX_TAPS_DEF;
    int                         rand_items = 0;
    int                         burst;
    int                         taps;
    logic [WET_GAIN_W-1:0]      gain;

    fir_convolution_with_feedback_mix_top i_dut (
        .aclk, .aresetn,
        .s_valid, .s_ready, .s_mode, .s_tap_index, .s_tap_value,
        .s_sample_in, .s_wet_mix, .s_feedback,
        .m_valid, .m_ready, .m_sample_out,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    fcm_conv_checker i_checker (
        .aclk, .aresetn,
        .s_valid, .s_ready, .s_mode, .s_tap_index, .s_tap_value,
        .s_sample_in, .s_wet_mix, .s_feedback,
        .m_valid, .m_ready, .m_sample_out,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .mismatch_count, .results_pending
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [SAMPLE_W-1:0] pick_s16();
        case ($urandom_range(0, 7))
            0: return S16_MAX;
            1: return S16_MIN;
            2: return '0;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [Q15_W-1:0] pick_q15();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return Q15_W'(Q15_ONE);
            default: return Q15_W'($urandom_range(0, Q15_ONE));
        endcase
    endfunction

    task automatic apb_write(input reg_idx_t r, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(r) << REG_SEL_BIT;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_item(
        input mode_t                md,
        input logic [TAP_IDX_W-1:0] ti,
        input logic [SAMPLE_W-1:0]  tv,
        input logic [SAMPLE_W-1:0]  x,
        input logic [Q15_W-1:0]     wm,
        input logic [Q15_W-1:0]     fb
    );
        if (idle_mode && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_mode      <= md;
        s_tap_index <= ti;
        s_tap_value <= tv;
        s_sample_in <= x;
        s_wet_mix   <= wm;
        s_feedback  <= fb;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_load(input logic [TAP_IDX_W-1:0] ti, input logic [SAMPLE_W-1:0] tv);
        send_item(MODE_LOAD, ti, tv, SAMPLE_W'($urandom), pick_q15(), pick_q15());
    endtask

    task automatic send_sample(
        input logic [SAMPLE_W-1:0] x,
        input logic [Q15_W-1:0]    wm,
        input logic [Q15_W-1:0]    fb
    );
        send_item(MODE_SAMPLE, TAP_IDX_W'($urandom), SAMPLE_W'($urandom), x, wm, fb);
    endtask

    // write every tap the current tap count reads before any sample uses it
    task automatic load_prefix();
        while (prefix_loaded < cur_taps) begin
            send_load(TAP_IDX_W'(prefix_loaded), pick_s16());
            prefix_loaded++;
            rand_items++;
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_regs(input logic [WET_GAIN_W-1:0] g, input int n);
        apb_write(REG_WET_GAIN, PDATA_W'(g));
        apb_write(REG_TAP_COUNT, PDATA_W'(n));
        cur_taps = n;
    endtask

    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_served != hold_reqs) begin
                hold_served++;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (idle_mode && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
    end

    initial begin
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_mode      <= MODE_LOAD;
        s_tap_index <= '0;
        s_tap_value <= '0;
        s_sample_in <= '0;
        s_wet_mix   <= '0;
        s_feedback  <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        set_regs(WET_GAIN_W'(65536), 4);
        send_load(TAP_IDX_W'(0), S16_MAX);
        send_load(TAP_IDX_W'(1), S16_MIN);
        send_load(TAP_IDX_W'(2), '0);
        send_load(TAP_IDX_W'(3), 16'sd1);
        send_load('1, 16'h5a5a);
        prefix_loaded = 4;
        send_sample(S16_MAX, '0, '0);
        send_sample(S16_MIN, Q15_W'(Q15_ONE), '0);
        send_sample(S16_MIN, Q15_W'(Q15_ONE), Q15_W'(Q15_ONE));
        send_sample('0, Q15_W'(16384), Q15_W'(16384));
        send_sample(16'sd12345, Q15_W'(Q15_ONE), '0);
        send_sample('1, '0, Q15_W'(Q15_ONE));

        // shrink to one tap: pointer sits beyond the new count
        wait_idle();
        set_regs(WET_GAIN_W'(65536), 1);
        send_sample(S16_MAX, Q15_W'(Q15_ONE), '0);
        send_sample(S16_MIN, Q15_W'(16384), Q15_W'(Q15_ONE));

        // full gain drives the wet term past the output range
        wait_idle();
        set_regs('1, 4);
        send_sample(S16_MAX, Q15_W'(Q15_ONE), '0);
        send_sample(S16_MIN, Q15_W'(Q15_ONE), '0);
        send_sample(S16_MAX, Q15_W'(Q15_ONE), Q15_W'(Q15_ONE));
        send_sample(16'sd100, Q15_W'(1), '0);

        wait_idle();
        set_regs('0, 4);
        send_sample(S16_MIN, Q15_W'(Q15_ONE), Q15_W'(16384));
        send_sample(S16_MAX, Q15_W'(16384), '0);

        // hold off the result side while samples keep coming
        wait_idle();
        set_regs(WET_GAIN_W'(65536), 4);
        idle_mode = 1'b0;
        hold_reqs++;
        repeat (12) send_sample(pick_s16(), pick_q15(), pick_q15());

        while (rand_items < RANDOM_ITEMS) begin
            wait_idle();
            case ($urandom_range(0, 5))
                0: gain = '0;
                1: gain = '1;
                2: gain = WET_GAIN_W'($urandom_range(0, 24'hFFFFFF));
                default: gain = WET_GAIN_W'($urandom_range(0, 24'h010000));
            endcase
            if (!wide_done && rand_items >= RANDOM_ITEMS / 2) begin
                taps = WIDE_TAPS;
                wide_done = 1'b1;
            end else begin
                case ($urandom_range(0, 9))
                    0: taps = 1;
                    1: taps = $urandom_range(65, 256);
                    2, 3: taps = $urandom_range(17, 64);
                    default: taps = $urandom_range(2, 16);
                endcase
            end
            set_regs(gain, taps);
            load_prefix();
            quiet     = (rand_items >= RANDOM_ITEMS - QUIET_ITEMS);
            idle_mode = !quiet && ($urandom_range(0, 3) != 0);
            burst = (taps == WIDE_TAPS) ? 6 : $urandom_range(15, 45);
            repeat (burst) begin
                if ($urandom_range(0, 4) == 0) begin
                    if ($urandom_range(0, 1) == 0)
                        send_load(TAP_IDX_W'($urandom_range(0, cur_taps - 1)), pick_s16());
                    else
                        send_load(TAP_IDX_W'($urandom_range(0, MAX_TAPS_DEF - 1)), pick_s16());
                end else begin
                    send_sample(pick_s16(), pick_q15(), pick_q15());
                end
                rand_items++;
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && results_pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
